>>> design/particle_pair_collision_time_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disc pair collision time block
// Clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PAIR_COLLISION_TIME_ASSERT_SVH
`define PARTICLE_PAIR_COLLISION_TIME_ASSERT_SVH

// Same-cycle implication.
`define PPCT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PPCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ppct_pkg.sv
// ----------------------------------------------------------------------------
// ppct_pkg
// Item types, field widths and status codes of the collision time block.
// ----------------------------------------------------------------------------
package ppct_pkg;

   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int TIME_W   = 48;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] STATUS_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAME      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVERGING = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP   = 3'd4;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic                       same_particle;
      logic signed [COORD_W-1:0]  first_x;
      logic signed [COORD_W-1:0]  first_y;
      logic signed [COORD_W-1:0]  first_vx;
      logic signed [COORD_W-1:0]  first_vy;
      logic [RADIUS_W-1:0]        first_radius;
      logic signed [COORD_W-1:0]  second_x;
      logic signed [COORD_W-1:0]  second_y;
      logic signed [COORD_W-1:0]  second_vx;
      logic signed [COORD_W-1:0]  second_vy;
      logic [RADIUS_W-1:0]        second_radius;
   } req_type;

   typedef struct packed {
      logic                will_hit;
      logic [TIME_W-1:0]   hit_time;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> design/particle_pair_collision_time.sv
// Throughput: one item per cycle; the 66 square root steps and 48 divider
// steps are each a pipeline stage of their own, so no unit is shared.
// A stalled result freezes the whole pipeline, and req_stall follows it.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// particle_pair_collision_time
// Predicts the time until two hard discs touch, one disc pair per cycle.
// ----------------------------------------------------------------------------
module particle_pair_collision_time
   import ppct_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Widths of the intermediate values. Differences are 33 bits, products
   // of differences 66 bits, and the discriminant fits in 132 bits whenever
   // its square root is needed.
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int MAG_W      = PROD_W;
   localparam int HALF_W     = MAG_W / 2;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int NUM_W      = ROOT_W + FRAC_BITS;
   localparam int CMP_W      = ROOT_W + TIME_W;

   // Control that rides along with every item once its class is known.
   // decided means the result no longer depends on the square root or the
   // quotient; sat marks a quotient that does not fit into hit_time.
   typedef struct packed {
      logic                decided;
      logic                will_hit;
      logic [STATUS_W-1:0] status;
      logic                sat;
   } ctl_type;

   typedef struct packed {
      logic                     same;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dvx;
      logic signed [DIFF_W-1:0] dvy;
      logic [COORD_W-1:0]       sigma;
   } s1_type;

   typedef struct packed {
      logic                     same;
      logic signed [PROD_W-1:0] p_xv;
      logic signed [PROD_W-1:0] p_yv;
      logic [PROD_W-1:0]        p_vx;
      logic [PROD_W-1:0]        p_vy;
      logic [PROD_W-1:0]        p_xx;
      logic [PROD_W-1:0]        p_yy;
      logic [2*COORD_W-1:0]     p_ss;
   } s2_type;

   typedef struct packed {
      logic                     same;
      logic signed [PROD_W:0]   dvdr;
      logic [PROD_W-1:0]        dvdv;
      logic [PROD_W-1:0]        drdr;
      logic [2*COORD_W-1:0]     ss;
   } s3_type;

   typedef struct packed {
      logic                     same;
      logic                     diverging;
      logic                     no_motion;
      logic signed [PROD_W:0]   dvdr;
      logic [PROD_W-1:0]        dvdv;
      logic signed [PROD_W:0]   q;
   } s4_type;

   typedef struct packed {
      logic                same;
      logic                diverging;
      logic                no_motion;
      logic                q_neg;
      logic [MAG_W-1:0]    a_mag;
      logic [MAG_W-1:0]    q_mag;
      logic [MAG_W-1:0]    dvdv;
   } s5_type;

   typedef struct packed {
      logic                same;
      logic                diverging;
      logic                no_motion;
      logic                q_neg;
      logic [MAG_W-1:0]    a_mag;
      logic [MAG_W-1:0]    dvdv;
      logic [MAG_W-1:0]    aa_ll;
      logic [MAG_W-1:0]    aa_lh;
      logic [MAG_W-1:0]    aa_hh;
      logic [MAG_W-1:0]    vq_ll;
      logic [MAG_W-1:0]    vq_lh;
      logic [MAG_W-1:0]    vq_hl;
      logic [MAG_W-1:0]    vq_hh;
   } s6_type;

   typedef struct packed {
      logic                same;
      logic                diverging;
      logic                no_motion;
      logic                q_neg;
      logic [MAG_W-1:0]    a_mag;
      logic [MAG_W-1:0]    dvdv;
      logic [SQ_W-1:0]     sq;
      logic [SQ_W-1:0]     m;
   } s7_type;

   typedef struct packed {
      ctl_type             ctl;
      logic [SQ_W-1:0]     rad;
      logic [ROOT_W+1:0]   rem;
      logic [ROOT_W-1:0]   root;
      logic [MAG_W-1:0]    a_mag;
      logic [MAG_W-1:0]    dvdv;
   } sq_stage_type;

   typedef struct packed {
      ctl_type             ctl;
      logic [ROOT_W-1:0]   num;
      logic [MAG_W-1:0]    dvdv;
   } nm_type;

   typedef struct packed {
      ctl_type             ctl;
      logic [MAG_W-1:0]    rem;
      logic [TIME_W-1:0]   nlow;
      logic [TIME_W-1:0]   quot;
      logic [MAG_W-1:0]    dvdv;
   } dv_stage_type;

   // The whole pipeline moves as one; it holds only while a result waits.
   logic adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, nm_valid_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;
   nm_type nm_in, nm_ff;

   logic         sq_valid_ff [0:SQRT_STEPS];
   sq_stage_type sq_ff       [0:SQRT_STEPS];
   sq_stage_type sq0_in;
   logic         dv_valid_ff [0:TIME_W];
   dv_stage_type dv_ff       [0:TIME_W];
   dv_stage_type dv0_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [SQ_W+1:0]  d_diff;
   logic             d_neg;
   logic [NUM_W-1:0] n_full;
   logic             ovf;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage 1: relative position and velocity, contact distance.
   always_comb begin
      s1_in.same  = req_data.same_particle;
      s1_in.dx    = $signed({req_data.second_x[COORD_W-1], req_data.second_x})
                  - $signed({req_data.first_x[COORD_W-1], req_data.first_x});
      s1_in.dy    = $signed({req_data.second_y[COORD_W-1], req_data.second_y})
                  - $signed({req_data.first_y[COORD_W-1], req_data.first_y});
      s1_in.dvx   = $signed({req_data.second_vx[COORD_W-1], req_data.second_vx})
                  - $signed({req_data.first_vx[COORD_W-1], req_data.first_vx});
      s1_in.dvy   = $signed({req_data.second_vy[COORD_W-1], req_data.second_vy})
                  - $signed({req_data.first_vy[COORD_W-1], req_data.first_vy});
      s1_in.sigma = {1'b0, req_data.first_radius} + {1'b0, req_data.second_radius};
   end

   // Stage 2: the six 33 by 33 products and the 32 by 32 square of sigma, side by side.
   always_comb begin
      s2_in.same = s1_ff.same;
      s2_in.p_xv = s1_ff.dx * s1_ff.dvx;
      s2_in.p_yv = s1_ff.dy * s1_ff.dvy;
      s2_in.p_vx = s1_ff.dvx * s1_ff.dvx;
      s2_in.p_vy = s1_ff.dvy * s1_ff.dvy;
      s2_in.p_xx = s1_ff.dx * s1_ff.dx;
      s2_in.p_yy = s1_ff.dy * s1_ff.dy;
      s2_in.p_ss = s1_ff.sigma * s1_ff.sigma;
   end

   // Stage 3: the dot products.
   always_comb begin
      s3_in.same = s2_ff.same;
      s3_in.dvdr = (PROD_W+1)'(s2_ff.p_xv) + (PROD_W+1)'(s2_ff.p_yv);
      s3_in.dvdv = s2_ff.p_vx + s2_ff.p_vy;
      s3_in.drdr = s2_ff.p_xx + s2_ff.p_yy;
      s3_in.ss   = s2_ff.p_ss;
   end

   // Stage 4: gap term and the early classification flags.
   always_comb begin
      s4_in.same      = s3_ff.same;
      s4_in.diverging = !s3_ff.dvdr[PROD_W] && (s3_ff.dvdr != '0);
      s4_in.no_motion = (s3_ff.dvdv == '0);
      s4_in.dvdr      = s3_ff.dvdr;
      s4_in.dvdv      = s3_ff.dvdv;
      s4_in.q         = $signed({1'b0, s3_ff.drdr}) - $signed({3'b0, s3_ff.ss});
   end

   // Stage 5: magnitudes, so the wide products below are unsigned.
   always_comb begin
      s5_in.same      = s4_ff.same;
      s5_in.diverging = s4_ff.diverging;
      s5_in.no_motion = s4_ff.no_motion;
      s5_in.q_neg     = s4_ff.q[PROD_W];
      s5_in.a_mag     = s4_ff.dvdr[PROD_W] ? (~s4_ff.dvdr[MAG_W-1:0] + MAG_W'(1))
                                           : s4_ff.dvdr[MAG_W-1:0];
      s5_in.q_mag     = s4_ff.q[PROD_W] ? (~s4_ff.q[MAG_W-1:0] + MAG_W'(1))
                                        : s4_ff.q[MAG_W-1:0];
      s5_in.dvdv      = s4_ff.dvdv;
   end

   // Stage 6: partial products of dvdr squared and of dvdv times the gap term.
   always_comb begin
      s6_in.same      = s5_ff.same;
      s6_in.diverging = s5_ff.diverging;
      s6_in.no_motion = s5_ff.no_motion;
      s6_in.q_neg     = s5_ff.q_neg;
      s6_in.a_mag     = s5_ff.a_mag;
      s6_in.dvdv      = s5_ff.dvdv;
      s6_in.aa_ll     = s5_ff.a_mag[HALF_W-1:0] * s5_ff.a_mag[HALF_W-1:0];
      s6_in.aa_lh     = s5_ff.a_mag[HALF_W-1:0] * s5_ff.a_mag[MAG_W-1:HALF_W];
      s6_in.aa_hh     = s5_ff.a_mag[MAG_W-1:HALF_W] * s5_ff.a_mag[MAG_W-1:HALF_W];
      s6_in.vq_ll     = s5_ff.dvdv[HALF_W-1:0] * s5_ff.q_mag[HALF_W-1:0];
      s6_in.vq_lh     = s5_ff.dvdv[HALF_W-1:0] * s5_ff.q_mag[MAG_W-1:HALF_W];
      s6_in.vq_hl     = s5_ff.dvdv[MAG_W-1:HALF_W] * s5_ff.q_mag[HALF_W-1:0];
      s6_in.vq_hh     = s5_ff.dvdv[MAG_W-1:HALF_W] * s5_ff.q_mag[MAG_W-1:HALF_W];
   end

   // Stage 7: the partial products summed into the two full-width terms.
   always_comb begin
      s7_in.same      = s6_ff.same;
      s7_in.diverging = s6_ff.diverging;
      s7_in.no_motion = s6_ff.no_motion;
      s7_in.q_neg     = s6_ff.q_neg;
      s7_in.a_mag     = s6_ff.a_mag;
      s7_in.dvdv      = s6_ff.dvdv;
      s7_in.sq        = (SQ_W'(s6_ff.aa_hh) << MAG_W)
                      + (SQ_W'(s6_ff.aa_lh) << (HALF_W + 1))
                      + SQ_W'(s6_ff.aa_ll);
      s7_in.m         = (SQ_W'(s6_ff.vq_hh) << MAG_W)
                      + ((SQ_W'(s6_ff.vq_lh) + SQ_W'(s6_ff.vq_hl)) << HALF_W)
                      + SQ_W'(s6_ff.vq_ll);
   end

   // Stage 8: discriminant and the final class of every case that needs
   // no square root. With an overlap the gap term is negative, so the
   // discriminant is a sum and never negative there.
   always_comb begin
      d_diff = {2'b00, s7_ff.sq} - {2'b00, s7_ff.m};
      d_neg  = !s7_ff.q_neg && d_diff[SQ_W+1];

      sq0_in.ctl.sat      = 1'b0;
      sq0_in.ctl.decided  = 1'b1;
      sq0_in.ctl.will_hit = 1'b0;
      if (s7_ff.same) begin
         sq0_in.ctl.status = STATUS_SAME;
      end else if (s7_ff.diverging) begin
         sq0_in.ctl.status = STATUS_DIVERGING;
      end else if (s7_ff.no_motion || d_neg) begin
         sq0_in.ctl.status = STATUS_MISS;
      end else if (s7_ff.q_neg) begin
         sq0_in.ctl.status   = STATUS_OVERLAP;
         sq0_in.ctl.will_hit = 1'b1;
      end else begin
         sq0_in.ctl.status   = STATUS_HIT;
         sq0_in.ctl.will_hit = 1'b1;
         sq0_in.ctl.decided  = 1'b0;
      end
      sq0_in.rad   = sq0_in.ctl.decided ? '0 : d_diff[SQ_W-1:0];
      sq0_in.rem   = '0;
      sq0_in.root  = '0;
      sq0_in.a_mag = s7_ff.a_mag;
      sq0_in.dvdv  = s7_ff.dvdv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         s6_valid_ff    <= 1'b0;
         s7_valid_ff    <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= req_valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
         s5_valid_ff    <= s4_valid_ff;
         s6_valid_ff    <= s5_valid_ff;
         s7_valid_ff    <= s6_valid_ff;
         sq_valid_ff[0] <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         s5_ff    <= s5_in;
         s6_ff    <= s6_in;
         s7_ff    <= s7_in;
         sq_ff[0] <= sq0_in;
      end
   end

   // Square root, two radicand bits a stage, one root bit a stage.
   // The remainder never exceeds twice the partial root, so its top two bits
   // are zero before each shift.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic              take;
      sq_stage_type      step_in;

      always_comb begin
         rem_sh        = {sq_ff[k].rem[ROOT_W-1:0], sq_ff[k].rad[SQ_W-1:SQ_W-2]};
         trial         = {sq_ff[k].root, 2'b01};
         take          = (rem_sh >= trial);
         step_in       = sq_ff[k];
         step_in.rad   = sq_ff[k].rad << 2;
         step_in.rem   = take ? (rem_sh - trial) : rem_sh;
         step_in.root  = {sq_ff[k].root[ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= step_in;
         end
      end
   end

   // Numerator of the time: -dvdr minus the root. It is never negative
   // because the root cannot exceed the magnitude of dvdr here.
   always_comb begin
      nm_in.ctl  = sq_ff[SQRT_STEPS].ctl;
      nm_in.num  = sq_ff[SQRT_STEPS].a_mag - sq_ff[SQRT_STEPS].root;
      nm_in.dvdv = sq_ff[SQRT_STEPS].a_mag == '0 ? sq_ff[SQRT_STEPS].dvdv
                                                 : sq_ff[SQRT_STEPS].dvdv;
   end

   // Divider setup: the quotient saturates when the scaled numerator
   // reaches dvdv times the output range; otherwise the leading remainder
   // is already below dvdv and only the low quotient bits remain.
   always_comb begin
      n_full         = {nm_ff.num, FRAC_BITS'(0)};
      ovf            = (CMP_W'(n_full) >= {nm_ff.dvdv, TIME_W'(0)});
      dv0_in.ctl     = nm_ff.ctl;
      dv0_in.ctl.sat = ovf;
      dv0_in.rem     = MAG_W'(n_full >> TIME_W);
      dv0_in.nlow    = n_full[TIME_W-1:0];
      dv0_in.quot    = '0;
      dv0_in.dvdv    = nm_ff.dvdv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         nm_valid_ff    <= sq_valid_ff[SQRT_STEPS];
         dv_valid_ff[0] <= nm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_ff    <= nm_in;
         dv_ff[0] <= dv0_in;
      end
   end

   // Restoring division, one quotient bit a stage, most significant first.
   for (genvar j = 0; j < TIME_W; j++) begin : g_div
      logic [MAG_W:0] rem_sh;
      logic           take;
      dv_stage_type   step_in;

      always_comb begin
         rem_sh       = {dv_ff[j].rem, dv_ff[j].nlow[TIME_W-1]};
         take         = (rem_sh >= {1'b0, dv_ff[j].dvdv});
         step_in      = dv_ff[j];
         step_in.rem  = take ? MAG_W'(rem_sh - {1'b0, dv_ff[j].dvdv})
                             : rem_sh[MAG_W-1:0];
         step_in.nlow = dv_ff[j].nlow << 1;
         step_in.quot = {dv_ff[j].quot[TIME_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j+1] <= step_in;
         end
      end
   end

   // Result register: classified cases carry a zero time, hits carry the
   // quotient or the saturated maximum.
   always_comb begin
      rsp_data_in.will_hit = dv_ff[TIME_W].ctl.will_hit;
      rsp_data_in.status   = dv_ff[TIME_W].ctl.status;
      if (dv_ff[TIME_W].ctl.decided) begin
         rsp_data_in.hit_time = '0;
      end else if (dv_ff[TIME_W].ctl.sat) begin
         rsp_data_in.hit_time = TIME_MAX;
      end else begin
         rsp_data_in.hit_time = dv_ff[TIME_W].quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid_ff[TIME_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> design/ppct_checker.sv
// ----------------------------------------------------------------------------
// ppct_checker
// Port-level checks of the collision time block, bound to its top level.
// ----------------------------------------------------------------------------
`include "particle_pair_collision_time_assert.svh"

module ppct_checker
   import ppct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `PPCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `PPCT_ASSERT_IMPLIES(a_stall_back, rsp_valid && rsp_stall, req_stall, "input taken while output blocked")
   `PPCT_ASSERT_IMPLIES(a_no_hit_zero, rsp_valid && !rsp_data.will_hit, rsp_data.hit_time == '0, "time without hit")
   `PPCT_ASSERT_IMPLIES(a_hit_status, rsp_valid && rsp_data.will_hit, rsp_data.status == STATUS_HIT || rsp_data.status == STATUS_OVERLAP, "hit with a no-hit status")
   `PPCT_ASSERT_IMPLIES(a_overlap_zero, rsp_valid && rsp_data.status == STATUS_OVERLAP, rsp_data.will_hit && rsp_data.hit_time == '0, "overlap not clamped")

endmodule

bind particle_pair_collision_time ppct_checker u_ppct_checker (.*);

>>> bench/tb_particle_pair_collision_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_pair_collision_time
// Self-checking bench for the disc pair collision time block. A short table of
// directed pairs runs first. Some rows carry expected results typed in by hand,
// and the rest are checked against a predictor with full-width arithmetic.
// 1840 random pairs follow, mostly discs closing on each other, spread
// over phases with different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_particle_pair_collision_time;
   import ppct_pkg::*;

   localparam int FRAC = 16;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN = 160;

   typedef struct {
      req_type pair;
      bit      typed;
      rsp_type result;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Expected contact results, oldest first.
   rsp_type contact_q[$];
   // Hand-typed results that go with items not yet accepted, in send order.
   bit      typed_flag_q[$];
   rsp_type typed_result_q[$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;

   particle_pair_collision_time #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact contact time of one pair. Everything is carried in 192 bits so no
   // product or difference can wrap.
   function automatic rsp_type predict_contact(req_type p);
      logic signed [191:0] dx, dy, dvx, dvy, sig, dvdr, dvdv, drdr, gap, disc;
      logic [191:0] root, cand, num, quo;
      rsp_type o;
      o.will_hit = 1'b0;
      o.hit_time = '0;
      o.status = STATUS_SAME;
      if (p.same_particle) return o;
      dx  = $signed(p.second_x)  - $signed(p.first_x);
      dy  = $signed(p.second_y)  - $signed(p.first_y);
      dvx = $signed(p.second_vx) - $signed(p.first_vx);
      dvy = $signed(p.second_vy) - $signed(p.first_vy);
      sig = '0;
      sig[31:0] = {1'b0, p.first_radius} + {1'b0, p.second_radius};
      dvdr = dx * dvx + dy * dvy;
      if (dvdr > 0) begin
         o.status = STATUS_DIVERGING;
         return o;
      end
      dvdv = dvx * dvx + dvy * dvy;
      o.status = STATUS_MISS;
      if (dvdv == 0) return o;
      drdr = dx * dx + dy * dy;
      gap  = drdr - sig * sig;
      disc = dvdr * dvdr - dvdv * gap;
      if (disc < 0) return o;
      o.will_hit = 1'b1;
      if (gap < 0) begin
         o.status = STATUS_OVERLAP;
         return o;
      end
      // Integer square root, rounded down; the compare is unsigned.
      root = '0;
      for (int b = 95; b >= 0; b--) begin
         cand = root | (192'd1 << b);
         if (cand * cand <= 192'(disc)) root = cand;
      end
      num = (192'(-dvdr) - root) << FRAC;
      quo = num / 192'(dvdv);
      o.status = STATUS_HIT;
      o.hit_time = (quo > 192'(TIME_MAX)) ? TIME_MAX : quo[TIME_W-1:0];
      return o;
   endfunction

   function automatic row_type mk(bit same, int fx, int fy, int fvx, int fvy, int fr,
                                  int sx, int sy, int svx, int svy, int sr,
                                  bit typed, bit hit, longint tm, logic [2:0] st);
      row_type r;
      r.pair = '{same, fx, fy, fvx, fvy, fr[30:0], sx, sy, svx, svy, sr[30:0]};
      r.typed = typed;
      r.result = '{hit, tm[47:0], st};
      return r;
   endfunction

   // Random pair: mostly discs closing in on each other, with some noise.
   function automatic req_type random_pair();
      req_type p;
      logic [319:0] rnd;
      int kind, dx, dy, shift;
      kind = $urandom_range(99);
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      p = rnd[$bits(req_type)-1:0];
      p.same_particle = (kind < 14) ? 1'b1 : 1'b0;
      if (kind < 6) p.same_particle = $urandom_range(1);
      if (kind >= 14) begin
         dx = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
         dy = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
         shift = $urandom_range(8);
         p.first_x  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
         p.first_y  = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
         p.second_x = p.first_x + dx;
         p.second_y = p.first_y + dy;
         p.first_vx = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         p.first_vy = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         p.second_vx = p.first_vx - (dx >>> shift) + $signed($urandom_range(2047)) - 1024;
         p.second_vy = p.first_vy - (dy >>> shift) + $signed($urandom_range(2047)) - 1024;
         p.first_radius  = RADIUS_W'($urandom_range(32'h0020_0000));
         p.second_radius = RADIUS_W'($urandom_range(32'h0020_0000));
         if (kind >= 96) p.second_vx = p.first_vx;
         if (kind >= 98) p.second_vy = p.first_vy;
      end
      return p;
   endfunction

   // Offers one item and returns once it has been accepted. Valid is only
   // lowered while idling, never in the step that raises it again.
   task automatic offer(input req_type p, input bit typed, input rsp_type res);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      typed_flag_q.push_back(typed);
      typed_result_q.push_back(res);
      req_valid <= 1'b1;
      req_data <= p;
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
   endtask

   task automatic wait_drained();
      while (contact_q.size() != 0) @(posedge clock);
   endtask

   // On acceptance the expectation is the hand-typed one if the row has it,
   // otherwise the predictor's.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (typed_flag_q.pop_front()) contact_q.push_back(typed_result_q.pop_front());
         else begin
            void'(typed_result_q.pop_front());
            contact_q.push_back(predict_contact(req_data));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (contact_q.size() == 0) begin
            $display("%0t: result with nothing expected: hit=%0d time=%h status=%0d",
                     $realtime, rsp_data.will_hit, rsp_data.hit_time, rsp_data.status);
            errors++;
         end else begin
            rsp_type want;
            want = contact_q.pop_front();
            if (rsp_data.will_hit !== want.will_hit || rsp_data.hit_time !== want.hit_time
                || rsp_data.status !== want.status) begin
               $display("%0t: expected hit=%0d time=%h status=%0d, got hit=%0d time=%h status=%0d",
                        $realtime, want.will_hit, want.hit_time, want.status,
                        rsp_data.will_hit, rsp_data.hit_time, rsp_data.status);
               errors++;
            end
         end
      end
   end

   // Receiver. A long hold asked for by the stimulus is counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      #5ms;
      $display("tb_particle_pair_collision_time NOT OK");
      $finish;
   end

   initial begin
      row_type rows[$];
      rsp_type none;
      none = '0;
      // Same particle, no relative motion at all, then same particle at the field extremes.
      rows.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, STATUS_SAME));
      rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, STATUS_MISS));
      rows.push_back(mk(1, -1, -1, -1, -1, 32'h7fffffff, -1, -1, -1, -1, 32'h7fffffff,
                        1, 0, 0, STATUS_SAME));
      // Moving apart.
      rows.push_back(mk(0, 0, 0, 0, 0, 65536, 65536, 0, 65536, 0, 0,
                        1, 0, 0, STATUS_DIVERGING));
      // Already overlapping while closing: clamped to time zero.
      rows.push_back(mk(0, 0, 0, 0, 0, 65536, 65536, 0, -65536, 0, 65536,
                        1, 1, 0, STATUS_OVERLAP));
      // Exactly touching: a normal hit at time zero.
      rows.push_back(mk(0, 0, 0, 0, 0, 65536, 131072, 0, -65536, 0, 65536,
                        1, 1, 0, STATUS_HIT));
      // Head-on at distance 4 with radius 1 each and closing speed 1: time 2.
      rows.push_back(mk(0, 0, 0, 0, 0, 65536, 262144, 0, -65536, 0, 65536,
                        1, 1, 131072, STATUS_HIT));
      // Passing wide of each other.
      rows.push_back(mk(0, 0, 0, 0, 0, 65536, 262144, 1048576, -65536, 0, 65536,
                        1, 0, 0, STATUS_MISS));
      // Same relative motion, zero velocity difference but far apart.
      rows.push_back(mk(0, 5, 7, 99, 99, 3, 900, 900, 99, 99, 3, 1, 0, 0, STATUS_MISS));
      // Field extremes and two small cases, checked by the predictor.
      rows.push_back(mk(0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
      rows.push_back(mk(0, 32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff,
                        32'h7ffffffe, 32'h7fffffff, -1, 0, 32'h7fffffff, 0, 0, 0, 0));
      rows.push_back(mk(0, 32'h80000000, 0, 0, 0, 0, 32'h7fffffff, 0, -1, 0, 0,
                        0, 0, 0, 0));
      rows.push_back(mk(0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0,
                        32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0,
                        0, 0, 0, 0));
      rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 0, 0, 0, 0));
      rows.push_back(mk(0, 100, 100, 3, 1, 40, -100, -100, -3, -1, 40, 0, 0, 0, 0));
      rows.push_back(mk(0, 0, 0, 1, 1, 1, 1000, 1000, -1, 0, 1, 0, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) offer(rows[i].pair, rows[i].typed, rows[i].result);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (int n = 0; n < 460; n++) begin
            // In the first phase the receiver holds off long enough for the
            // pipeline to fill and push back on the input.
            if (ph == 0 && n == 100) hold_asked++;
            // In the second phase the sender waits for every result once.
            if (ph == 1 && n == 200) begin
               req_valid <= 1'b0;
               wait_drained();
               @(posedge clock);
            end
            offer(random_pair(), 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && contact_q.size() == 0) begin
         $display("tb_particle_pair_collision_time OK");
      end else begin
         $display("tb_particle_pair_collision_time NOT OK");
      end
      $finish;
   end

endmodule
